@@ rtl/tdkq_pkg.sv @@
// ----------------------------------------------------------------------------
// tdkq_pkg
// types, constants and helpers shared by the tick delayed key action queue
// ----------------------------------------------------------------------------
package tdkq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RES_W = $clog2(MAX_RESULTS + 1);
  localparam int unsigned NR_W  = (CNT_W > RES_W) ? CNT_W : RES_W;
  localparam int unsigned SUM_W = $clog2(2 * QUEUE_DEPTH);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_TAP     = 2'd2;
  localparam logic [1:0] ACT_OTHER   = 2'd3;

  localparam logic [1:0] RES_ACK   = 2'd0;
  localparam logic [1:0] RES_REG   = 2'd1;
  localparam logic [1:0] RES_UNREG = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [1:0]  action_type;
    logic [7:0]  key_index;
    logic [15:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        accepted;
    logic [7:0]  out_key;
    logic [15:0] out_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  etype;
    logic [7:0]  key;
    logic [15:0] code;
    logic [7:0]  ticks;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC_RD,
    ST_EXEC_DO,
    ST_FLUSH
  } state_e;

  // circular index: base plus offset, offset at most the depth
  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      s = s - SUM_W'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/tdkq_ram.sv @@
// ----------------------------------------------------------------------------
// tdkq_ram
// simple dual port synchronous ram, one write and one registered read
// ----------------------------------------------------------------------------
module tdkq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 34
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/tdkq_out_stage.sv @@
// ----------------------------------------------------------------------------
// tdkq_out_stage
// result register between the sequencer and the output channel
// ----------------------------------------------------------------------------
module tdkq_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  tdkq_pkg::out_item_t data_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tdkq_pkg::out_item_t out_data_o
);

  logic                valid_q;
  tdkq_pkg::out_item_t data_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

@@ rtl/tdkq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tdkq_ctrl
// queue sequencer: push, countdown scan and in-order retire over the ram
// ----------------------------------------------------------------------------
module tdkq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tdkq_pkg::in_item_t  in_data_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  output tdkq_pkg::mem_req_t  mem_req_o,
  input  tdkq_pkg::entry_t    mem_rdata_i,
  output logic                out_load_o,
  output tdkq_pkg::out_item_t out_data_o,
  input  logic                out_free_i
);

  tdkq_pkg::state_e state_q, state_d;

  logic [tdkq_pkg::IDX_W-1:0] head_q, head_d;
  logic [tdkq_pkg::CNT_W-1:0] count_q, count_d;
  logic [7:0]                 delay_q;
  logic [tdkq_pkg::CNT_W-1:0] rd_off_q, rd_off_d;
  logic                       rv_q, rv_d;
  logic [tdkq_pkg::IDX_W-1:0] wa_q, wa_d;
  logic [tdkq_pkg::CNT_W-1:0] nready_q, nready_d;
  logic                       prefix_q, prefix_d;
  logic [tdkq_pkg::IDX_W-1:0] ex_base_q, ex_base_d;
  logic [tdkq_pkg::CNT_W-1:0] ex_idx_q, ex_idx_d;
  tdkq_pkg::out_item_t        pend_q, pend_d;
  logic                       pend_v_q, pend_v_d;

  logic                in_fire;
  logic                scan_done;
  logic                can_push;
  logic                need_emit;
  logic                go;
  tdkq_pkg::out_item_t ex_res;
  logic [7:0]          t;
  tdkq_pkg::entry_t    ent;

  assign in_ready_o = (state_q == tdkq_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign scan_done  = (rd_off_q == count_q) && !rv_q;
  assign can_push   = count_q < tdkq_pkg::FULL_CNT;

  // result of the retiring entry
  always_comb begin
    ex_res          = '0;
    ex_res.out_key  = mem_rdata_i.key;
    ex_res.out_code = mem_rdata_i.code;
    need_emit       = 1'b0;
    case (mem_rdata_i.etype)
      tdkq_pkg::ACT_PRESS: begin
        ex_res.result_kind = tdkq_pkg::RES_REG;
        need_emit          = 1'b1;
      end
      tdkq_pkg::ACT_RELEASE: begin
        ex_res.result_kind = tdkq_pkg::RES_UNREG;
        need_emit          = 1'b1;
      end
      tdkq_pkg::ACT_TAP: begin
        ex_res.result_kind = tdkq_pkg::RES_REG;
        need_emit          = can_push;
      end
      default: begin
        need_emit = 1'b0;
      end
    endcase
  end

  assign go = !need_emit || !pend_v_q || out_free_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tdkq_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.kind == tdkq_pkg::KIND_PUSH) begin
            state_d = tdkq_pkg::ST_FLUSH;
          end else if (count_q != '0) begin
            state_d = tdkq_pkg::ST_SCAN;
          end
        end
      end
      tdkq_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = (nready_q != '0) ? tdkq_pkg::ST_EXEC_RD : tdkq_pkg::ST_FLUSH;
        end
      end
      tdkq_pkg::ST_EXEC_RD: begin
        state_d = tdkq_pkg::ST_EXEC_DO;
      end
      tdkq_pkg::ST_EXEC_DO: begin
        if (go) begin
          state_d = (ex_idx_q + tdkq_pkg::CNT_W'(1) == nready_q) ?
                    tdkq_pkg::ST_FLUSH : tdkq_pkg::ST_EXEC_RD;
        end
      end
      tdkq_pkg::ST_FLUSH: begin
        if (!pend_v_q || out_free_i) begin
          state_d = tdkq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tdkq_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    rd_off_d   = rd_off_q;
    rv_d       = 1'b0;
    wa_d       = wa_q;
    nready_d   = nready_q;
    prefix_d   = prefix_q;
    ex_base_d  = ex_base_q;
    ex_idx_d   = ex_idx_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    mem_req_o  = '0;
    out_load_o = 1'b0;
    out_data_o = pend_q;
    ent        = mem_rdata_i;
    t          = mem_rdata_i.ticks;
    case (state_q)
      tdkq_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.kind == tdkq_pkg::KIND_PUSH) begin
            if (can_push) begin
              mem_req_o.we          = 1'b1;
              mem_req_o.waddr       = tdkq_pkg::wrap_add(head_q, count_q);
              mem_req_o.wdata.etype = in_data_i.action_type;
              mem_req_o.wdata.key   = in_data_i.key_index;
              mem_req_o.wdata.code  = in_data_i.key_code;
              mem_req_o.wdata.ticks = delay_q;
              count_d               = count_q + tdkq_pkg::CNT_W'(1);
            end
            pend_d             = '0;
            pend_d.result_kind = tdkq_pkg::RES_ACK;
            pend_d.accepted    = can_push;
            pend_v_d           = 1'b1;
          end else begin
            rd_off_d = '0;
            nready_d = '0;
            prefix_d = 1'b1;
          end
        end
      end
      tdkq_pkg::ST_SCAN: begin
        // write back the entry read last cycle
        if (rv_q) begin
          if (t > delay_q) begin
            t = delay_q;
          end
          if (t != 8'd0) begin
            t        = t - 8'd1;
            prefix_d = 1'b0;
          end else if (prefix_q && (tdkq_pkg::NR_W'(nready_q) <
                                    tdkq_pkg::NR_W'(tdkq_pkg::MAX_RESULTS))) begin
            nready_d = nready_q + tdkq_pkg::CNT_W'(1);
          end else begin
            prefix_d = 1'b0;
          end
          ent.ticks       = t;
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = wa_q;
          mem_req_o.wdata = ent;
        end
        if (rd_off_q != count_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = tdkq_pkg::wrap_add(head_q, rd_off_q);
          wa_d            = tdkq_pkg::wrap_add(head_q, rd_off_q);
          rd_off_d        = rd_off_q + tdkq_pkg::CNT_W'(1);
          rv_d            = 1'b1;
        end
        if (scan_done) begin
          head_d    = tdkq_pkg::wrap_add(head_q, nready_q);
          count_d   = count_q - nready_q;
          ex_base_d = head_q;
          ex_idx_d  = '0;
        end
      end
      tdkq_pkg::ST_EXEC_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = tdkq_pkg::wrap_add(ex_base_q, ex_idx_q);
      end
      tdkq_pkg::ST_EXEC_DO: begin
        if (go) begin
          if (mem_rdata_i.etype == tdkq_pkg::ACT_TAP && can_push) begin
            mem_req_o.we          = 1'b1;
            mem_req_o.waddr       = tdkq_pkg::wrap_add(head_q, count_q);
            mem_req_o.wdata.etype = tdkq_pkg::ACT_RELEASE;
            mem_req_o.wdata.key   = mem_rdata_i.key;
            mem_req_o.wdata.code  = mem_rdata_i.code;
            mem_req_o.wdata.ticks = delay_q;
            count_d               = count_q + tdkq_pkg::CNT_W'(1);
          end
          if (need_emit) begin
            if (pend_v_q) begin
              out_load_o      = 1'b1;
              out_data_o.last = 1'b0;
            end
            pend_d   = ex_res;
            pend_v_d = 1'b1;
          end
          ex_idx_d = ex_idx_q + tdkq_pkg::CNT_W'(1);
        end
      end
      tdkq_pkg::ST_FLUSH: begin
        out_data_o.last = 1'b1;
        if (pend_v_q && out_free_i) begin
          out_load_o = 1'b1;
          pend_v_d   = 1'b0;
        end
      end
      default: begin
        pend_v_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tdkq_pkg::ST_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      delay_q  <= 8'd0;
      rv_q     <= 1'b0;
      pend_v_q <= 1'b0;
      rd_off_q <= '0;
      nready_q <= '0;
      prefix_q <= 1'b0;
      ex_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      rv_q     <= rv_d;
      pend_v_q <= pend_v_d;
      rd_off_q <= rd_off_d;
      nready_q <= nready_d;
      prefix_q <= prefix_d;
      ex_idx_q <= ex_idx_d;
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q      <= wa_d;
    ex_base_q <= ex_base_d;
    pend_q    <= pend_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tdkq_pkg::FULL_CNT)
    else $error("entry count above queue depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tdkq_pkg::IDX_W + 1)'(head_q) < (tdkq_pkg::IDX_W + 1)'(tdkq_pkg::QUEUE_DEPTH))
    else $error("head pointer out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |-> out_free_i)
    else $error("result loaded into a busy output register");

  a_ready_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdkq_pkg::ST_SCAN) |-> (nready_q <= rd_off_q))
    else $error("more ready entries than entries scanned");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdkq_pkg::ST_IDLE) |-> !pend_v_q)
    else $error("pending result left over in idle");

endmodule

@@ rtl/tick_delayed_key_action_queue_top.sv @@
// ----------------------------------------------------------------------------
// tick_delayed_key_action_queue_top
// circular queue of key actions, each carried out after a tick delay
// ----------------------------------------------------------------------------
// input channel (valid/ready): a push stores an action with a countdown of
// delay_ticks, a tick counts all stored actions down and retires the ready
// run at the head. output channel (valid/ready): acknowledges and register /
// unregister results, the final result of a transaction marked with last.
// cfg_we_i: user writes delay_ticks only while the block is idle, unenforced.
// one transaction is worked on at a time; in_ready_o is high in idle only.
// push: the acknowledge is held pending, then loaded into the output register.
// tick: a scan over the stored entries, read-modify-write pipelined over the
// single read and write port of the entry ram, then a read state and an
// execute state per retired entry; the flush state sends the last result.
// a tick on an empty queue leaves the block idle and gives no result.
// a stalled receiver holds the output register; the sequencer waits on it
// with one further result held internally.
// reset clears head, count, delay_ticks and the control state; the entry ram
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module tick_delayed_key_action_queue_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tdkq_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tdkq_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);

  tdkq_pkg::mem_req_t              mem_req;
  logic [tdkq_pkg::ENTRY_W-1:0]    mem_rdata;
  tdkq_pkg::entry_t                mem_rdata_s;
  logic                            out_load;
  tdkq_pkg::out_item_t             out_data;
  logic                            out_free;

  assign mem_rdata_s = mem_rdata;

  tdkq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata_s),
    .out_load_o  (out_load),
    .out_data_o  (out_data),
    .out_free_i  (out_free)
  );

  tdkq_ram #(
    .DEPTH (tdkq_pkg::QUEUE_DEPTH),
    .WIDTH (tdkq_pkg::ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  tdkq_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .data_i      (out_data),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
